// File: hw/rtl/pgf_pkg.sv
// ----------------------------------------------------------------------------
// pgf_pkg: shared widths and codes for the pairwise gravity force pipeline
// Fixed-point widths of every intermediate value and the register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgf_pkg;

    // multiplier limb
    localparam int LIMB_W     = 32;

    // input and register fields
    localparam int POS_W      = 32;
    localparam int MASS_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int G_W        = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // intermediate values
    localparam int DIFF_W     = POS_W + 1;        // signed position difference
    localparam int MAG_W      = 48;               // |diff| * scale, Q24.24
    localparam int SQ_W       = 2 * MAG_W;        // one squared component
    localparam int D2_W       = SQ_W + 1;         // squared distance
    localparam int ROOT_W     = 50;               // integer square root
    localparam int DEN_W      = D2_W + ROOT_W;    // d2 * root
    localparam int GM_W       = G_W + MASS_W;     // G * m1
    localparam int GMM_W      = GM_W + MASS_W;    // G * m1 * m2
    localparam int NUMP_W     = GMM_W + MAG_W;    // numerator before scaling
    localparam int FRAC_SHIFT = 16;
    localparam int NUM_W      = NUMP_W + FRAC_SHIFT;
    localparam int FORCE_W    = 64;
    localparam int OVF_SHIFT  = FORCE_W - FRAC_SHIFT;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISTANCE_SCALE   = 8'd0,
        CFG_GRAVITY_CONSTANT = 8'd1
    } cfg_index_t;

endpackage

// File: hw/rtl/pairwise_gravity_force.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force: Newtonian attraction between two bodies in 2D
// Fixed-point pipeline: scaled displacement, squared distance, square root,
// divisor, numerators and a restoring division for both force components.
//
//   channel  | dir | handshake            | contents
//   ---------+-----+----------------------+------------------------------------
//   s_       | in  | s_tvalid / s_tready  | two positions and two masses
//   m_       | out | m_tvalid / m_tready  | force vector, coincident, saturated
//   cfg_     | in  | cfg_valid / cfg_ready| register index and write data
//
// One request enters per cycle while the output is not stalled; the stages
// include the 50 root cells, the 64 division cells and the multiplier rows.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stalled output holds the whole pipeline; s_tready follows that stall.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_gravity_force (
    input  logic         aclk,
    input  logic         aresetn,
    // first_x, first_y, second_x, second_y, first_mass, second_mass
    input  logic [191:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // force_x, force_y
    output logic [127:0] m_tdata,
    // coincident, saturated
    output logic [1:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [pgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pgf_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             nx;
        logic             ny;
    } vec_t;

    typedef struct packed {
        vec_t              v;
        logic [GM_W-1:0]   gm;
        logic [MASS_W-1:0] m2;
    } body_t;

    typedef struct packed {
        logic [SQ_W-1:0] mx2;
        body_t           b;
    } sq_side_t;

    typedef struct packed {
        logic [D2_W-1:0] d2;
        body_t           b;
    } root_side_t;

    typedef struct packed {
        logic  zero;
        body_t b;
    } den_side_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic             zero;
        vec_t             v;
    } gmm_side_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [GMM_W-1:0] gmm;
        logic             zero;
        vec_t             v;
    } numx_side_t;

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [NUMP_W-1:0] numx;
        logic              zero;
        vec_t              v;
    } numy_side_t;

    typedef struct packed {
        logic nx;
        logic ny;
        logic big_x;
        logic big_y;
        logic zero;
    } flags_t;

    localparam int OVF_W = DEN_W + OVF_SHIFT;
    localparam logic [FORCE_W-1:0] POS_LIM = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] NEG_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

    logic en;

    // ---------------- configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [G_W-1:0]     g_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_W'(256);
            g_reg     <= G_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DISTANCE_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_GRAVITY_CONSTANT: g_reg     <= cfg_data[G_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage: scaled displacement and G*m1
    logic signed [POS_W-1:0] fx_in, fy_in, sx_in, sy_in;
    logic [MASS_W-1:0]       m1_in, m2_in;
    logic signed [DIFF_W-1:0] ddx, ddy;
    logic [DIFF_W-1:0]       ax, ay;
    logic [DIFF_W+SCALE_W-1:0] px, py;
    body_t                   in_body_next, in_body_reg;
    logic                    in_vld_reg;

    assign fx_in = $signed(s_tdata[31:0]);
    assign fy_in = $signed(s_tdata[63:32]);
    assign sx_in = $signed(s_tdata[95:64]);
    assign sy_in = $signed(s_tdata[127:96]);
    assign m1_in = s_tdata[159:128];
    assign m2_in = s_tdata[191:160];

    assign ddx = DIFF_W'(sx_in) - DIFF_W'(fx_in);
    assign ddy = DIFF_W'(sy_in) - DIFF_W'(fy_in);
    assign ax  = ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
    assign ay  = ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
    assign px  = ax * scale_reg;
    assign py  = ay * scale_reg;

    always_comb begin
        in_body_next.v.mx = px[MAG_W-1:0];
        in_body_next.v.my = py[MAG_W-1:0];
        in_body_next.v.nx = ddx[DIFF_W-1];
        in_body_next.v.ny = ddy[DIFF_W-1];
        in_body_next.gm   = g_reg * m1_in;
        in_body_next.m2   = m2_in;
    end

    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_body_reg <= in_body_next;
        end
    end

    // ---------------- squares of both components
    logic            sqx_vld, sqy_vld;
    logic [SQ_W-1:0] sqx_p, sqy_p;
    body_t           sqx_side;
    sq_side_t        sqy_in_side, sqy_side;

    pgf_mul #(.WA(MAG_W), .WB(MAG_W), .WS($bits(body_t))) u_sq_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(in_vld_reg), .i_a(in_body_reg.v.mx), .i_b(in_body_reg.v.mx),
        .i_side(in_body_reg),
        .o_vld(sqx_vld), .o_p(sqx_p), .o_side(sqx_side)
    );

    assign sqy_in_side.mx2 = sqx_p;
    assign sqy_in_side.b   = sqx_side;

    pgf_mul #(.WA(MAG_W), .WB(MAG_W), .WS($bits(sq_side_t))) u_sq_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(sqx_vld), .i_a(sqx_side.v.my), .i_b(sqx_side.v.my),
        .i_side(sqy_in_side),
        .o_vld(sqy_vld), .o_p(sqy_p), .o_side(sqy_side)
    );

    // ---------------- squared distance
    logic            d2_vld_reg;
    logic [D2_W-1:0] d2_reg;
    body_t           d2_body_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_vld_reg <= 1'b0;
        end else if (en) begin
            d2_vld_reg <= sqy_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg      <= D2_W'(sqy_side.mx2) + D2_W'(sqy_p);
            d2_body_reg <= sqy_side.b;
        end
    end

    // ---------------- square root, one cell per root bit
    logic              sq_vld  [ROOT_W+1];
    logic [D2_W-1:0]   sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    root_side_t        sq_side [ROOT_W+1];

    assign sq_vld[0]       = d2_vld_reg;
    assign sq_rem[0]       = d2_reg;
    assign sq_root[0]      = '0;
    assign sq_side[0].d2   = d2_reg;
    assign sq_side[0].b    = d2_body_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        pgf_sqrt_cell #(
            .WR(D2_W), .WQ(ROOT_W), .BIT(ROOT_W - 1 - k), .WS($bits(root_side_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .i_vld(sq_vld[k]), .i_rem(sq_rem[k]), .i_root(sq_root[k]),
            .i_side(sq_side[k]),
            .o_vld(sq_vld[k+1]), .o_rem(sq_rem[k+1]), .o_root(sq_root[k+1]),
            .o_side(sq_side[k+1])
        );
    end

    // ---------------- divisor d2 * root
    den_side_t        den_in_side, den_side;
    logic             den_vld;
    logic [DEN_W-1:0] den_p;

    assign den_in_side.zero = (sq_side[ROOT_W].d2 == '0);
    assign den_in_side.b    = sq_side[ROOT_W].b;

    pgf_mul #(.WA(D2_W), .WB(ROOT_W), .WS($bits(den_side_t))) u_den (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(sq_vld[ROOT_W]), .i_a(sq_side[ROOT_W].d2), .i_b(sq_root[ROOT_W]),
        .i_side(den_in_side),
        .o_vld(den_vld), .o_p(den_p), .o_side(den_side)
    );

    // ---------------- G * m1 * m2
    gmm_side_t        gmm_in_side, gmm_side;
    logic             gmm_vld;
    logic [GMM_W-1:0] gmm_p;

    assign gmm_in_side.den  = den_p;
    assign gmm_in_side.zero = den_side.zero;
    assign gmm_in_side.v    = den_side.b.v;

    pgf_mul #(.WA(GM_W), .WB(MASS_W), .WS($bits(gmm_side_t))) u_gmm (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(den_vld), .i_a(den_side.b.gm), .i_b(den_side.b.m2),
        .i_side(gmm_in_side),
        .o_vld(gmm_vld), .o_p(gmm_p), .o_side(gmm_side)
    );

    // ---------------- numerators
    numx_side_t        nx_in_side, nx_side;
    numy_side_t        ny_in_side, ny_side;
    logic              nx_vld, ny_vld;
    logic [NUMP_W-1:0] nx_p, ny_p;

    assign nx_in_side.den  = gmm_side.den;
    assign nx_in_side.gmm  = gmm_p;
    assign nx_in_side.zero = gmm_side.zero;
    assign nx_in_side.v    = gmm_side.v;

    pgf_mul #(.WA(GMM_W), .WB(MAG_W), .WS($bits(numx_side_t))) u_num_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(gmm_vld), .i_a(gmm_p), .i_b(gmm_side.v.mx),
        .i_side(nx_in_side),
        .o_vld(nx_vld), .o_p(nx_p), .o_side(nx_side)
    );

    assign ny_in_side.den  = nx_side.den;
    assign ny_in_side.numx = nx_p;
    assign ny_in_side.zero = nx_side.zero;
    assign ny_in_side.v    = nx_side.v;

    pgf_mul #(.WA(GMM_W), .WB(MAG_W), .WS($bits(numy_side_t))) u_num_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_vld(nx_vld), .i_a(nx_side.gmm), .i_b(nx_side.v.my),
        .i_side(ny_in_side),
        .o_vld(ny_vld), .o_p(ny_p), .o_side(ny_side)
    );

    // ---------------- overflow check: quotient of 2^64 or more
    logic             ovf_vld_reg;
    logic [DEN_W-1:0] ovf_den_reg;
    logic [NUM_W-1:0] ovf_num_x_reg, ovf_num_y_reg;
    flags_t           ovf_flags_reg, ovf_flags_next;
    logic [OVF_W-1:0] den_top;

    assign den_top = OVF_W'(ny_side.den) << OVF_SHIFT;

    always_comb begin
        ovf_flags_next.nx    = ny_side.v.nx;
        ovf_flags_next.ny    = ny_side.v.ny;
        ovf_flags_next.big_x = (OVF_W'(ny_side.numx) >= den_top);
        ovf_flags_next.big_y = (OVF_W'(ny_p) >= den_top);
        ovf_flags_next.zero  = ny_side.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_vld_reg <= 1'b0;
        end else if (en) begin
            ovf_vld_reg <= ny_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_den_reg   <= ny_side.den;
            ovf_num_x_reg <= {ny_side.numx, {FRAC_SHIFT{1'b0}}};
            ovf_num_y_reg <= {ny_p, {FRAC_SHIFT{1'b0}}};
            ovf_flags_reg <= ovf_flags_next;
        end
    end

    // ---------------- division, one cell per quotient bit
    logic               dv_vld   [FORCE_W+1];
    logic [DEN_W-1:0]   dv_den   [FORCE_W+1];
    logic [NUM_W-1:0]   dv_rem_x [FORCE_W+1];
    logic [NUM_W-1:0]   dv_rem_y [FORCE_W+1];
    logic [FORCE_W-1:0] dv_q_x   [FORCE_W+1];
    logic [FORCE_W-1:0] dv_q_y   [FORCE_W+1];
    flags_t             dv_flags [FORCE_W+1];

    assign dv_vld[0]   = ovf_vld_reg;
    assign dv_den[0]   = ovf_den_reg;
    assign dv_rem_x[0] = ovf_num_x_reg;
    assign dv_rem_y[0] = ovf_num_y_reg;
    assign dv_q_x[0]   = '0;
    assign dv_q_y[0]   = '0;
    assign dv_flags[0] = ovf_flags_reg;

    for (genvar k = 0; k < FORCE_W; k++) begin : g_div
        pgf_div_cell #(
            .WR(NUM_W), .WD(DEN_W), .WQ(FORCE_W), .BIT(FORCE_W - 1 - k),
            .WS($bits(flags_t))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .i_vld(dv_vld[k]), .i_den(dv_den[k]),
            .i_rem_x(dv_rem_x[k]), .i_rem_y(dv_rem_y[k]),
            .i_q_x(dv_q_x[k]), .i_q_y(dv_q_y[k]), .i_side(dv_flags[k]),
            .o_vld(dv_vld[k+1]), .o_den(dv_den[k+1]),
            .o_rem_x(dv_rem_x[k+1]), .o_rem_y(dv_rem_y[k+1]),
            .o_q_x(dv_q_x[k+1]), .o_q_y(dv_q_y[k+1]), .o_side(dv_flags[k+1])
        );
    end

    // ---------------- clamp, sign and output register
    flags_t             fin;
    logic [FORCE_W-1:0] lim_x, lim_y, mag_x, mag_y;
    logic               sat_x, sat_y;
    logic [FORCE_W-1:0] force_x_next, force_y_next;
    logic               coin_next, sat_next;

    logic               out_vld_reg;
    logic [FORCE_W-1:0] force_x_reg, force_y_reg;
    logic               coin_reg, sat_reg;

    assign fin   = dv_flags[FORCE_W];
    assign lim_x = fin.nx ? NEG_LIM : POS_LIM;
    assign lim_y = fin.ny ? NEG_LIM : POS_LIM;
    assign sat_x = fin.big_x || (dv_q_x[FORCE_W] > lim_x);
    assign sat_y = fin.big_y || (dv_q_y[FORCE_W] > lim_y);
    assign mag_x = sat_x ? lim_x : dv_q_x[FORCE_W];
    assign mag_y = sat_y ? lim_y : dv_q_y[FORCE_W];

    always_comb begin
        if (fin.zero) begin
            force_x_next = '0;
            force_y_next = '0;
            coin_next    = 1'b1;
            sat_next     = 1'b0;
        end else begin
            force_x_next = fin.nx ? (FORCE_W'(0) - mag_x) : mag_x;
            force_y_next = fin.ny ? (FORCE_W'(0) - mag_y) : mag_y;
            coin_next    = 1'b0;
            sat_next     = sat_x || sat_y;
        end
    end

    assign en = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld[FORCE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            force_x_reg <= force_x_next;
            force_y_reg <= force_y_next;
            coin_reg    <= coin_next;
            sat_reg     <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {force_y_reg, force_x_reg};
    assign m_tuser  = {sat_reg, coin_reg};

endmodule

// File: hw/rtl/pgf_mul.sv
// ----------------------------------------------------------------------------
// pgf_mul: pipelined wide multiplier
// Row of cells, each adding one limb-by-limb partial product to a running
// accumulator and handing operands, sideband and valid to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgf_mul #(
    parameter int WA = 64,
    parameter int WB = 32,
    parameter int WS = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          i_vld,
    input  logic [WA-1:0] i_a,
    input  logic [WB-1:0] i_b,
    input  logic [WS-1:0] i_side,
    output logic          o_vld,
    output logic [WA+WB-1:0] o_p,
    output logic [WS-1:0] o_side
);
    import pgf_pkg::*;

    localparam int LA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int LB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int NS = LA * LB;
    localparam int WF = LIMB_W * (LA + LB);
    localparam int WP = WA + WB;

    logic [WF-1:0]        acc_reg  [NS];
    logic [LIMB_W*LA-1:0] a_reg    [NS];
    logic [LIMB_W*LB-1:0] b_reg    [NS];
    logic [WS-1:0]        side_reg [NS];
    logic                 vld_reg  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_cell
        localparam int I = s / LB;
        localparam int J = s % LB;

        logic [WF-1:0]          acc_in;
        logic [LIMB_W*LA-1:0]   a_in;
        logic [LIMB_W*LB-1:0]   b_in;
        logic [WS-1:0]          side_in;
        logic                   vld_in;
        logic [2*LIMB_W-1:0]    pp;
        logic [WF-1:0]          acc_next;

        if (s == 0) begin : g_head
            assign acc_in  = '0;
            assign a_in    = (LIMB_W*LA)'(i_a);
            assign b_in    = (LIMB_W*LB)'(i_b);
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_link
            assign acc_in  = acc_reg[s-1];
            assign a_in    = a_reg[s-1];
            assign b_in    = b_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // one partial product, shifted into place
        assign pp       = a_in[LIMB_W*I +: LIMB_W] * b_in[LIMB_W*J +: LIMB_W];
        assign acc_next = acc_in + (WF'(pp) << (LIMB_W * (I + J)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[s]  <= acc_next;
                a_reg[s]    <= a_in;
                b_reg[s]    <= b_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign o_vld  = vld_reg[NS-1];
    assign o_p    = acc_reg[NS-1][WP-1:0];
    assign o_side = side_reg[NS-1];

endmodule

// File: hw/rtl/pgf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pgf_sqrt_cell: one bit of a digit-by-digit integer square root
// Tries one root bit against the remaining radicand and hands on the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgf_sqrt_cell #(
    parameter int WR  = 97,
    parameter int WQ  = 50,
    parameter int BIT = 0,
    parameter int WS  = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          i_vld,
    input  logic [WR-1:0] i_rem,
    input  logic [WQ-1:0] i_root,
    input  logic [WS-1:0] i_side,
    output logic          o_vld,
    output logic [WR-1:0] o_rem,
    output logic [WQ-1:0] o_root,
    output logic [WS-1:0] o_side
);
    localparam int WC = (2 * WQ > WR) ? 2 * WQ : WR;

    logic [WC-1:0] trial;
    logic [WC-1:0] rem_ext;
    logic          take;
    logic          vld_reg;
    logic [WR-1:0] rem_reg,  rem_next;
    logic [WQ-1:0] root_reg, root_next;
    logic [WS-1:0] side_reg;

    // (root + 2^b)^2 - root^2
    assign trial   = (WC'(i_root) << (BIT + 1)) | (WC'(1) << (2 * BIT));
    assign rem_ext = WC'(i_rem);
    assign take    = (rem_ext >= trial);

    always_comb begin
        rem_next  = i_rem;
        root_next = i_root;
        if (take) begin
            rem_next  = i_rem - trial[WR-1:0];
            root_next = i_root | (WQ'(1) << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= i_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= i_side;
        end
    end

    assign o_vld  = vld_reg;
    assign o_rem  = rem_reg;
    assign o_root = root_reg;
    assign o_side = side_reg;

endmodule

// File: hw/rtl/pgf_div_cell.sv
// ----------------------------------------------------------------------------
// pgf_div_cell: one quotient bit of a restoring division, both components
// The x and y numerators share one divisor; each cell decides one bit of each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgf_div_cell #(
    parameter int WR  = 160,
    parameter int WD  = 147,
    parameter int WQ  = 64,
    parameter int BIT = 0,
    parameter int WS  = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          i_vld,
    input  logic [WD-1:0] i_den,
    input  logic [WR-1:0] i_rem_x,
    input  logic [WR-1:0] i_rem_y,
    input  logic [WQ-1:0] i_q_x,
    input  logic [WQ-1:0] i_q_y,
    input  logic [WS-1:0] i_side,
    output logic          o_vld,
    output logic [WD-1:0] o_den,
    output logic [WR-1:0] o_rem_x,
    output logic [WR-1:0] o_rem_y,
    output logic [WQ-1:0] o_q_x,
    output logic [WQ-1:0] o_q_y,
    output logic [WS-1:0] o_side
);
    localparam int WC = (WD + BIT > WR) ? WD + BIT : WR;

    logic [WC-1:0] dsh;
    logic          take_x, take_y;
    logic          vld_reg;
    logic [WD-1:0] den_reg;
    logic [WR-1:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [WQ-1:0] q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [WS-1:0] side_reg;

    // divisor aligned to this quotient bit
    assign dsh    = WC'(i_den) << BIT;
    assign take_x = (WC'(i_rem_x) >= dsh);
    assign take_y = (WC'(i_rem_y) >= dsh);

    always_comb begin
        rem_x_next = i_rem_x;
        rem_y_next = i_rem_y;
        q_x_next   = i_q_x;
        q_y_next   = i_q_y;
        if (take_x) begin
            rem_x_next = i_rem_x - dsh[WR-1:0];
            q_x_next   = i_q_x | (WQ'(1) << BIT);
        end
        if (take_y) begin
            rem_y_next = i_rem_y - dsh[WR-1:0];
            q_y_next   = i_q_y | (WQ'(1) << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= i_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= i_den;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            side_reg  <= i_side;
        end
    end

    assign o_vld   = vld_reg;
    assign o_den   = den_reg;
    assign o_rem_x = rem_x_reg;
    assign o_rem_y = rem_y_reg;
    assign o_q_x   = q_x_reg;
    assign o_q_y   = q_y_reg;
    assign o_side  = side_reg;

endmodule

// File: sim/pairwise_gravity_force_tb.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force_tb: self-checking bench for the gravity force pipeline
// Drives body pairs on the input stream and writes the scale and G registers
// between phases. Each accepted request is run through an in-bench model of
// the fixed-point force, and each result is compared field by field against
// the oldest prediction. Both stream sides idle and stall at random. A long
// output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_gravity_force_tb;

    import pgf_pkg::*;

    localparam int          LATENCY       = 148;
    localparam logic [7:0]  CFG_SPARE_IDX = 8'd2;
    localparam logic [7:0]  CFG_TOP_IDX   = 8'hFF;

    typedef struct packed {
        logic [31:0] second_mass;
        logic [31:0] first_mass;
        logic [31:0] second_y;
        logic [31:0] second_x;
        logic [31:0] first_y;
        logic [31:0] first_x;
    } body_pair_t;

    typedef struct packed {
        logic [63:0] force_x;
        logic [63:0] force_y;
        logic        coincident;
        logic        saturated;
    } force_t;

    logic         aclk;
    logic         aresetn;
    logic [191:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copies seen by the force model
    logic [15:0] model_scale;
    logic [31:0] model_gravity;

    force_t pending_forces[$];
    int     requests_taken;
    int     results_taken;
    int     cfg_taken;
    int     mismatch_count;
    int     stall_hold_cycles;
    bit     no_idle;

    pairwise_gravity_force uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // One component: sign * trunc(gmm * mag * 2^16 / den), clamped to 64 bits
    function automatic logic [63:0] axis_force(input logic [191:0] gmm,
                                               input logic [191:0] mag,
                                               input bit neg,
                                               input logic [191:0] den,
                                               inout bit sat);
        logic [191:0] quot;
        logic [191:0] limit;
        logic [63:0]  value;
        quot  = ((gmm * mag) << 16) / den;
        limit = neg ? (192'd1 << 63) : ((192'd1 << 63) - 192'd1);
        if (quot > limit) begin
            sat  = 1'b1;
            quot = limit;
        end
        value = quot[63:0];
        return neg ? -value : value;
    endfunction

    // Newtonian pull on body one from the current register copies
    function automatic force_t gravity_pull(input body_pair_t p);
        logic signed [33:0] dx, dy;
        logic [191:0] mx, my, d2, root, trial, den, gmm;
        bit nx, ny, sat;
        force_t f;
        dx  = $signed({{2{p.second_x[31]}}, p.second_x})
              - $signed({{2{p.first_x[31]}}, p.first_x});
        dy  = $signed({{2{p.second_y[31]}}, p.second_y})
              - $signed({{2{p.first_y[31]}}, p.first_y});
        nx  = dx < 0;
        ny  = dy < 0;
        mx  = 192'(unsigned'(nx ? -dx : dx)) * model_scale;
        my  = 192'(unsigned'(ny ? -dy : dy)) * model_scale;
        d2  = mx * mx + my * my;
        sat = 1'b0;
        f   = '0;
        if (d2 == 0) begin
            f.coincident = 1'b1;
        end else begin
            root = 0;
            for (int b = 49; b >= 0; b--) begin
                trial = root | (192'd1 << b);
                if (trial * trial <= d2) root = trial;
            end
            den       = d2 * root;
            gmm       = 192'(model_gravity) * p.first_mass * p.second_mass;
            f.force_x = axis_force(gmm, mx, nx, den, sat);
            f.force_y = axis_force(gmm, my, ny, den, sat);
        end
        f.saturated = sat;
        return f;
    endfunction

    // Predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        force_t want, got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_taken++;
                if (cfg_index == CFG_DISTANCE_SCALE) model_scale = cfg_data[15:0];
                else if (cfg_index == CFG_GRAVITY_CONSTANT) model_gravity = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                pending_forces.insert(pending_forces.size(),
                                      gravity_pull(body_pair_t'(s_tdata)));
                requests_taken++;
            end
            if (m_tvalid && m_tready) begin
                results_taken++;
                got = {m_tdata[63:0], m_tdata[127:64], m_tuser[0], m_tuser[1]};
                if (pending_forces.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: fx=%h fy=%h flags=%b",
                                 got.force_x, got.force_y, m_tuser);
                end else begin
                    want = pending_forces.pop_front();
                    if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
                        got.coincident !== want.coincident ||
                        got.saturated !== want.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: expected fx=%h fy=%h coin=%b sat=%b,",
                                     results_taken, want.force_x, want.force_y,
                                     want.coincident, want.saturated,
                                     " got fx=%h fy=%h coin=%b sat=%b",
                                     got.force_x, got.force_y, got.coincident,
                                     got.saturated);
                    end
                end
            end
        end
    end

    // Output side: random stall per result, plus a long hold-off on request
    initial begin
        int stall;
        int seen;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (stall_hold_cycles) @(negedge aclk);
                stall_hold_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            seen = results_taken;
            while (results_taken == seen && stall_hold_cycles == 0) @(negedge aclk);
        end
    end

    // Send one request; called and returns at a falling edge
    task automatic send_pair(input body_pair_t p);
        int gap;
        int seen;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= p;
        s_tvalid <= 1'b1;
        seen = requests_taken;
        do @(negedge aclk); while (requests_taken == seen);
    endtask

    // Hold the input idle until every prediction is matched and the pipe empties
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_forces.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        int seen;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        seen = cfg_taken;
        do @(negedge aclk); while (cfg_taken == seen);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_mass();
        logic [31:0] m;
        m = $urandom();
        return m >> $urandom_range(0, 31);
    endfunction

    // Mostly nearby pairs with varied spacing, some anywhere in the plane, now and then all zero
    function automatic body_pair_t rand_pair();
        body_pair_t p;
        int span;
        p.first_x     = $urandom();
        p.first_y     = $urandom();
        p.first_mass  = rand_mass();
        p.second_mass = rand_mass();
        if ($urandom_range(0, 3) == 0) begin
            p.second_x = $urandom();
            p.second_y = $urandom();
        end else begin
            span = $urandom_range(0, 30);
            p.second_x = p.first_x + ($signed($urandom()) >>> (31 - span));
            p.second_y = p.first_y + ($signed($urandom()) >>> (31 - span));
        end
        if ($urandom_range(0, 40) == 0) p = '{default: '0};
        return p;
    endfunction

    function automatic body_pair_t make_pair(input logic [31:0] x1, y1, x2, y2, m1, m2);
        body_pair_t p;
        p = '{second_mass: m2, first_mass: m1, second_y: y2, second_x: x2,
              first_y: y1, first_x: x1};
        return p;
    endfunction

    // Field extremes, coincidence, zero mass, zero G, zero scale, saturation, unused indexes
    task automatic test_directed();
        write_reg(CFG_GRAVITY_CONSTANT, 32'hFFFF_FFFF);
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0,
                            32'hFFFF_FFFF, 32'd7));
        send_pair(make_pair(32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'd5, 32'd5, 32'h0001_0005, 32'hFFFF_0005, 32'd0, 32'd99));
        send_pair(make_pair(32'd5, 32'd5, 32'h0001_0005, 32'hFFFF_0005, 32'd99, 32'd0));
        send_pair(make_pair(32'h0010_0000, 32'd0, 32'd0, 32'h0010_0000, 32'h0001_0000,
                            32'h0001_0000));
        drain_pipe();
        write_reg(CFG_GRAVITY_CONSTANT, 32'd0);
        send_pair(make_pair(32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain_pipe();
        write_reg(CFG_DISTANCE_SCALE, 32'd0);
        write_reg(CFG_GRAVITY_CONSTANT, 32'h8000_0000);
        send_pair(make_pair(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'd4));
        drain_pipe();
        write_reg(CFG_DISTANCE_SCALE, 32'd1);
        send_pair(make_pair(32'd0, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1));
        drain_pipe();
        write_reg(CFG_DISTANCE_SCALE, 32'd65535);
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd1000, 32'd1000));
        drain_pipe();
        // writes to unused indexes must leave the registers alone
        write_reg(CFG_SPARE_IDX, 32'd3);
        write_reg(CFG_TOP_IDX, 32'hDEAD_BEEF);
        send_pair(make_pair(32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd500, 32'd500));
        drain_pipe();
    endtask

    // Several register settings, extremes included, each with random traffic
    task automatic test_config_sweep();
        logic [15:0] scales[6];
        logic [31:0] gravities[6];
        scales    = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'($urandom_range(1, 65535)), 16'd16};
        gravities = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0000_1000, $urandom(), 32'h0100_0000};
        for (int s = 0; s < 6; s++) begin
            write_reg(CFG_DISTANCE_SCALE, {16'd0, scales[s]});
            write_reg(CFG_GRAVITY_CONSTANT, gravities[s]);
            no_idle = (s == 2);
            repeat (120) send_pair(rand_pair());
            drain_pipe();
        end
        no_idle = 1'b0;
    endtask

    // Random registers per burst, random idling in between stretches of none
    task automatic test_random_traffic();
        for (int burst = 0; burst < 10; burst++) begin
            write_reg(CFG_DISTANCE_SCALE, {16'd0, 16'($urandom())});
            write_reg(CFG_GRAVITY_CONSTANT, $urandom() >> $urandom_range(0, 31));
            no_idle = $urandom_range(0, 3) == 0;
            repeat (43) send_pair(rand_pair());
            drain_pipe();
        end
        no_idle = 1'b0;
    endtask

    // Hold the output off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        write_reg(CFG_DISTANCE_SCALE, 32'd256);
        write_reg(CFG_GRAVITY_CONSTANT, 32'h0001_0000);
        no_idle = 1'b1;
        stall_hold_cycles = 400;
        repeat (280) send_pair(rand_pair());
        no_idle = 1'b0;
        drain_pipe();
    endtask

    initial begin
        aclk              = 1'b0;
        aresetn           = 1'b0;
        s_tdata           = '0;
        s_tvalid          = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        model_scale       = 16'd256;
        model_gravity     = 32'd1;
        requests_taken    = 0;
        results_taken     = 0;
        cfg_taken         = 0;
        mismatch_count    = 0;
        stall_hold_cycles = 0;
        no_idle           = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_config_sweep();
        test_random_traffic();
        test_backpressure();

        if (mismatch_count == 0 && pending_forces.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
